/* rtl/core/piecewise_latency_histogram_core_macros.svh */
// Assertion helpers for the latency histogram core.
// Both expect signals named clk and rst_n in the enclosing module.
`ifndef PIECEWISE_LATENCY_HISTOGRAM_CORE_MACROS_SVH
`define PIECEWISE_LATENCY_HISTOGRAM_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset
`define PHL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define PHL_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/phl_pkg.sv */
`default_nettype none

package phl_pkg;

  // Histogram geometry
  localparam int GROUPS     = 3;
  localparam int COLUMNS    = 256;
  localparam int COUNT_BITS = 32;

  localparam int IDX_W = $clog2(COLUMNS);
  localparam int G_W   = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int VAL_W = 32;
  // Flat positions can reach three full 32-bit group spans
  localparam int POS_W = VAL_W + 2;
  localparam int SEL_W = 8;

  // Stream payload widths
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 72;
  localparam int OUT_USER_W = 2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_BOUND_FIRST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_FIRST  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOUND_SECOND = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_SECOND = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOUND_THIRD  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_THIRD  = 3'd5;

  // Input command codes
  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_READ   = 1'b1;

  // Layout rebuild control from the sequencer
  typedef struct packed {
    logic             upd;
    logic             clr;
    logic [G_W-1:0]   g;
    logic [VAL_W-1:0] quo;
  } lay_ctl_t;

  // Layout status and the division operands of the group being rebuilt
  typedef struct packed {
    logic             dirty;
    logic [IDX_W-1:0] sat;
    logic [VAL_W-1:0] num;
    logic [VAL_W-1:0] den;
  } lay_sts_t;

  // Group chosen for a recorded duration
  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] num;
    logic [VAL_W-1:0] den;
    logic [POS_W-1:0] start;
  } rec_grp_t;

  // Group holding a flat column, for its left edge
  typedef struct packed {
    logic [IDX_W-1:0] diff;
    logic [VAL_W-1:0] w;
    logic [VAL_W-1:0] base;
  } edge_grp_t;

endpackage

`default_nettype wire

/* rtl/core/piecewise_latency_histogram_core.sv */
// Latency histogram with up to three groups of equal-width columns.
// Input stream (in_*): one request per item. in_tuser is the command: record a
//   duration, or read back one column. Output stream (out_*): exactly one
//   response per request, in request order.
// Config channel (cfg_*): always ready. Each write triggers a layout rebuild
//   that runs one 32-step division per group; the input stays stalled until it
//   is done. Write only while no request is open.
// Request flow: a record inside the groups runs the 32-step radix-2 divider that
//   finds the column, followed by a read-modify-write of the counter memory. A
//   read, or a record past every group, skips the divider; a read past the
//   saturation column also skips the memory read. A new request is accepted
//   only after the previous one has reached the output register.
// Reset: synchronous, active low. Configuration returns to bound 0, width 1,
//   and a clearing pass writes zero to every counter, one per cycle; in_tready
//   stays low during the pass.
// Backpressure: a finished response waits in the output register. The next
//   request is accepted and worked on meanwhile, and it stalls only when its
//   own response is ready and the output register is still full.
`include "piecewise_latency_histogram_core_macros.svh"
`default_nettype none

module piecewise_latency_histogram_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // Input requests
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [phl_pkg::IN_DATA_W-1:0]  in_tdata,   // duration_us[31:0], column_sel[39:32]
  input  wire logic                           in_tuser,   // cmd[0]
  // Responses
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [phl_pkg::OUT_DATA_W-1:0]      out_tdata,  // column_hit[7:0], count[39:8],
                                                          // left_edge_us[71:40]
  output logic [phl_pkg::OUT_USER_W-1:0]      out_tuser,  // in_saturation[0], bad_column[1]
  // Configuration writes
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [phl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [phl_pkg::VAL_W-1:0]      cfg_data
);

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_LSTART = 8'b0000_0100,
    S_LWAIT  = 8'b0000_1000,
    S_DIV    = 8'b0001_0000,
    S_READ   = 8'b0010_0000,
    S_MUL    = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_t;

  localparam int IW = phl_pkg::IDX_W;
  localparam int CW = phl_pkg::COUNT_BITS;
  localparam int VW = phl_pkg::VAL_W;

  state_t                    state_r, state_nxt;
  logic [phl_pkg::G_W-1:0]   g_r, g_nxt;
  logic [IW-1:0]             clr_r, clr_nxt;
  logic                      out_tvalid_r, out_tvalid_nxt;

  logic                      rec_r, rec_nxt;
  logic                      bad_r, bad_nxt;
  logic [phl_pkg::SEL_W-1:0] sel_r, sel_nxt;
  logic [IW-1:0]             idx_r, idx_nxt;
  logic [phl_pkg::POS_W-1:0] rstart_r, rstart_nxt;
  logic [IW-1:0]             diff_r;
  logic [VW-1:0]             ew_r;
  logic [VW-1:0]             base_r;
  logic [VW-1:0]             prod_r;
  logic [CW-1:0]             val_r;

  logic [7:0]                hit_o_r;
  logic [31:0]               cnt_o_r;
  logic [31:0]               edge_o_r;
  logic                      sat_o_r;
  logic                      bad_o_r;

  logic                      in_fire;
  logic                      in_cmd;
  logic [VW-1:0]             in_dur;
  logic [phl_pkg::SEL_W-1:0] in_sel;
  logic                      out_free;
  logic                      out_load;

  phl_pkg::lay_ctl_t         lay_ctl;
  phl_pkg::lay_sts_t         lay_sts;
  phl_pkg::rec_grp_t         rec_grp;
  phl_pkg::edge_grp_t        edge_grp;

  logic                      div_start;
  logic [VW-1:0]             div_num;
  logic [VW-1:0]             div_den;
  logic                      div_done;
  logic [VW-1:0]             div_quo;
  logic [phl_pkg::POS_W:0]   flat_sum;

  logic                      ram_we;
  logic [IW-1:0]             ram_waddr;
  logic [CW-1:0]             ram_wdata;
  logic                      ram_re;
  logic [CW-1:0]             ram_rdata;
  logic [CW-1:0]             cnt_inc;

  // Unpack the request
  assign in_cmd    = in_tuser;
  assign in_dur    = in_tdata[31:0];
  assign in_sel    = in_tdata[39:32];
  assign in_tready = (state_r == S_IDLE) && !lay_sts.dirty;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_tvalid_r || out_tready;
  assign out_load  = (state_r == S_OUT) && out_free;

  phl_layout u_layout (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctl       (lay_ctl),
    .rec_dur   (in_dur),
    .edge_idx  (idx_r),
    .sts       (lay_sts),
    .rec       (rec_grp),
    .edg       (edge_grp)
  );

  // Share the divider between layout rebuild and column lookup
  assign div_start = (state_r == S_LSTART) ||
                     (in_fire && (in_cmd == phl_pkg::CMD_RECORD) && rec_grp.found);
  assign div_num   = (state_r == S_LSTART) ? lay_sts.num : rec_grp.num;
  assign div_den   = (state_r == S_LSTART) ? lay_sts.den : rec_grp.den;

  phl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Flat column = group start + quotient, capped at the saturation column
  assign flat_sum = {1'b0, rstart_r} + (phl_pkg::POS_W + 1)'(div_quo);

  // Saturating counter increment
  assign cnt_inc = (ram_rdata == '1) ? ram_rdata : ram_rdata + 1'b1;

  // Counter memory: clearing pass after reset, then read-modify-write
  assign ram_re    = (state_r == S_READ);
  assign ram_we    = (state_r == S_CLEAR) || ((state_r == S_MUL) && rec_r);
  assign ram_waddr = (state_r == S_CLEAR) ? clr_r : idx_r;
  assign ram_wdata = (state_r == S_CLEAR) ? '0 : cnt_inc;

  phl_ram #(
    .DEPTH (phl_pkg::COLUMNS),
    .WIDTH (CW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    g_nxt          = g_r;
    clr_nxt        = clr_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    rec_nxt        = rec_r;
    bad_nxt        = bad_r;
    sel_nxt        = sel_r;
    idx_nxt        = idx_r;
    rstart_nxt     = rstart_r;
    lay_ctl        = '0;
    lay_ctl.g      = g_r;
    lay_ctl.quo    = div_quo;

    unique case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == IW'(phl_pkg::COLUMNS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (lay_sts.dirty) begin
          lay_ctl.clr = 1'b1;
          g_nxt       = '0;
          state_nxt   = S_LSTART;
        end else if (in_fire) begin
          sel_nxt = in_sel;
          bad_nxt = 1'b0;
          if (in_cmd == phl_pkg::CMD_RECORD) begin
            rec_nxt = 1'b1;
            if (rec_grp.found) begin
              rstart_nxt = rec_grp.start;
              state_nxt  = S_DIV;
            end else begin
              idx_nxt   = lay_sts.sat;
              state_nxt = S_READ;
            end
          end else begin
            rec_nxt = 1'b0;
            if (phl_pkg::POS_W'(in_sel) > phl_pkg::POS_W'(lay_sts.sat)) begin
              bad_nxt   = 1'b1;
              state_nxt = S_OUT;
            end else begin
              idx_nxt   = IW'(in_sel);
              state_nxt = S_READ;
            end
          end
        end
      end
      S_LSTART: begin
        state_nxt = S_LWAIT;
      end
      S_LWAIT: begin
        if (div_done) begin
          lay_ctl.upd = 1'b1;
          if (g_r == phl_pkg::G_W'(phl_pkg::GROUPS - 1)) begin
            state_nxt = S_IDLE;
          end else begin
            g_nxt     = g_r + 1'b1;
            state_nxt = S_LSTART;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          idx_nxt   = (flat_sum > (phl_pkg::POS_W + 1)'(lay_sts.sat)) ?
                      lay_sts.sat : IW'(flat_sum);
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_MUL;
      end
      S_MUL: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      g_r          <= '0;
      clr_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      g_r          <= g_nxt;
      clr_r        <= clr_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // Request payload and edge datapath
  always_ff @(posedge clk) begin
    rec_r    <= rec_nxt;
    bad_r    <= bad_nxt;
    sel_r    <= sel_nxt;
    idx_r    <= idx_nxt;
    rstart_r <= rstart_nxt;
    if (state_r == S_READ) begin
      diff_r <= edge_grp.diff;
      ew_r   <= edge_grp.w;
      base_r <= edge_grp.base;
    end
    if (state_r == S_MUL) begin
      prod_r <= VW'(diff_r * ew_r);
      val_r  <= rec_r ? cnt_inc : ram_rdata;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (out_load) begin
      hit_o_r  <= bad_r ? sel_r : 8'(idx_r);
      cnt_o_r  <= bad_r ? '0 : 32'(val_r);
      edge_o_r <= bad_r ? '0 : base_r + prod_r;
      sat_o_r  <= !bad_r && (idx_r == lay_sts.sat);
      bad_o_r  <= bad_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {edge_o_r, cnt_o_r, hit_o_r};
  assign out_tuser  = {bad_o_r, sat_o_r};

  // Checks
  `PHL_ASSERT_IMP(a_wr_in_range, ram_we && (state_r == S_MUL), idx_r <= lay_sts.sat, "bad write")
  `PHL_ASSERT_IMP(a_bad_zero, out_tvalid && bad_o_r, {cnt_o_r, edge_o_r, sat_o_r} == '0, "bad data")
  `PHL_ASSERT_IMP(a_div_owner, div_done, (state_r == S_DIV) || (state_r == S_LWAIT), "stray divide")
  `PHL_ASSERT_NXT(a_accept_busy, in_fire, !in_tready, "second request accepted back to back")

endmodule

`default_nettype wire

/* rtl/core/phl_div.sv */
`default_nettype none

module phl_div (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [phl_pkg::VAL_W-1:0] num,
  input  wire logic [phl_pkg::VAL_W-1:0] den,
  output logic                          done,
  output logic [phl_pkg::VAL_W-1:0]      quo
);

  localparam int CNT_W = $clog2(phl_pkg::VAL_W);

  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [phl_pkg::VAL_W-1:0] rem_r, rem_nxt;
  logic [phl_pkg::VAL_W-1:0] quo_r, quo_nxt;
  logic [phl_pkg::VAL_W-1:0] den_r, den_nxt;
  logic [phl_pkg::VAL_W:0]   trial;
  logic [phl_pkg::VAL_W:0]   diff;
  logic                      ge;

  // One restoring step: shift in the next dividend bit, try the subtract
  always_comb begin
    trial = {rem_r, quo_r[phl_pkg::VAL_W-1]};
    diff  = trial - {1'b0, den_r};
    ge    = (trial >= {1'b0, den_r});
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = num;
      den_nxt  = den;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[phl_pkg::VAL_W-1:0] : trial[phl_pkg::VAL_W-1:0];
      quo_nxt = {quo_r[phl_pkg::VAL_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(phl_pkg::VAL_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

/* rtl/core/phl_ram.sv */
`default_nettype none

module phl_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* rtl/core/phl_layout.sv */
`default_nettype none

module phl_layout (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  input  wire logic [phl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [phl_pkg::VAL_W-1:0]     cfg_data,
  input  wire phl_pkg::lay_ctl_t             ctl,
  input  wire logic [phl_pkg::VAL_W-1:0]     rec_dur,
  input  wire logic [phl_pkg::IDX_W-1:0]     edge_idx,
  output phl_pkg::lay_sts_t                  sts,
  output phl_pkg::rec_grp_t                  rec,
  output phl_pkg::edge_grp_t                 edg
);

  localparam int NG = phl_pkg::GROUPS;

  // Configuration registers
  logic [phl_pkg::VAL_W-1:0] bound_r [3];
  logic [phl_pkg::VAL_W-1:0] width_r [3];
  logic                      dirty_r;

  // Layout derived from the configuration
  logic [phl_pkg::VAL_W-1:0] lo_r    [NG];
  logic [phl_pkg::VAL_W-1:0] hi_r    [NG];
  logic [phl_pkg::VAL_W-1:0] w_r     [NG];
  logic [phl_pkg::VAL_W-1:0] cnt_r   [NG];
  logic [phl_pkg::POS_W-1:0] start_r [NG];

  logic [phl_pkg::VAL_W-1:0] prev_a  [NG];
  logic [phl_pkg::VAL_W-1:0] b_a     [NG];
  logic [phl_pkg::VAL_W-1:0] wd_a    [NG];
  logic [phl_pkg::POS_W-1:0] end_a   [NG];
  logic [phl_pkg::POS_W-1:0] stp_a   [NG];
  logic [phl_pkg::POS_W-1:0] total;
  logic [phl_pkg::POS_W-1:0] eidx;
  logic [phl_pkg::G_W-1:0]   rsel;
  logic [phl_pkg::G_W-1:0]   esel;
  logic                      efound;

  // Write configuration registers; any write marks the layout stale
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        bound_r[i] <= '0;
        width_r[i] <= phl_pkg::VAL_W'(1);
      end
    end else if (cfg_valid) begin
      unique case (cfg_index)
        phl_pkg::REG_BOUND_FIRST:  bound_r[0] <= cfg_data;
        phl_pkg::REG_WIDTH_FIRST:  width_r[0] <= cfg_data;
        phl_pkg::REG_BOUND_SECOND: bound_r[1] <= cfg_data;
        phl_pkg::REG_WIDTH_SECOND: width_r[1] <= cfg_data;
        phl_pkg::REG_BOUND_THIRD:  bound_r[2] <= cfg_data;
        phl_pkg::REG_WIDTH_THIRD:  width_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dirty_r <= 1'b0;
    end else if (cfg_valid) begin
      dirty_r <= 1'b1;
    end else if (ctl.clr) begin
      dirty_r <= 1'b0;
    end
  end

  // Per-group span: clamp descending bounds, treat zero width as one
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      end_a[g] = start_r[g] + phl_pkg::POS_W'(cnt_r[g]);
    end
    prev_a[0] = '0;
    stp_a[0]  = '0;
    for (int g = 1; g < NG; g++) begin
      prev_a[g] = hi_r[g-1];
      stp_a[g]  = end_a[g-1];
    end
    for (int g = 0; g < NG; g++) begin
      b_a[g]  = (bound_r[g] < prev_a[g]) ? prev_a[g] : bound_r[g];
      wd_a[g] = (width_r[g] == '0) ? phl_pkg::VAL_W'(1) : width_r[g];
    end
    total = end_a[NG-1];
  end

  // Store one group once its column count is known
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int g = 0; g < NG; g++) begin
        lo_r[g]    <= '0;
        hi_r[g]    <= '0;
        w_r[g]     <= phl_pkg::VAL_W'(1);
        cnt_r[g]   <= '0;
        start_r[g] <= '0;
      end
    end else if (ctl.upd) begin
      lo_r[ctl.g]    <= prev_a[ctl.g];
      hi_r[ctl.g]    <= b_a[ctl.g];
      w_r[ctl.g]     <= wd_a[ctl.g];
      cnt_r[ctl.g]   <= ctl.quo;
      start_r[ctl.g] <= stp_a[ctl.g];
    end
  end

  always_comb begin
    sts.dirty = dirty_r;
    sts.sat   = (total < phl_pkg::POS_W'(phl_pkg::COLUMNS - 1)) ?
                phl_pkg::IDX_W'(total) : phl_pkg::IDX_W'(phl_pkg::COLUMNS - 1);
    sts.num   = b_a[ctl.g] - prev_a[ctl.g];
    sts.den   = wd_a[ctl.g];
  end

  // First group whose right bound exceeds the duration
  always_comb begin
    rec.found = 1'b0;
    rsel      = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (hi_r[g] > rec_dur) begin
        rec.found = 1'b1;
        rsel      = phl_pkg::G_W'(g);
      end
    end
    rec.num   = rec_dur - lo_r[rsel];
    rec.den   = w_r[rsel];
    rec.start = start_r[rsel];
  end

  // Group whose flat columns hold the index; past all groups the edge is the last bound
  always_comb begin
    eidx   = phl_pkg::POS_W'(edge_idx);
    efound = 1'b0;
    esel   = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (eidx >= start_r[g] && eidx < end_a[g]) begin
        efound = 1'b1;
        esel   = phl_pkg::G_W'(g);
      end
    end
    edg.diff = efound ? phl_pkg::IDX_W'(eidx - start_r[esel]) : '0;
    edg.w    = w_r[esel];
    edg.base = efound ? lo_r[esel] : hi_r[NG-1];
  end

endmodule

`default_nettype wire

/* tb/sv/tb_piecewise_latency_histogram_core.sv */
`default_nettype none

// Tracks histogram state and layout, predicts one response per request
class hist_scoreboard;
  typedef struct {
    bit [7:0]  column_hit;
    bit [31:0] count;
    bit [31:0] left_edge_us;
    bit        in_saturation;
    bit        bad_column;
  } column_report_t;

  bit [31:0] bound_reg [3];
  bit [31:0] width_reg [3];
  bit [phl_pkg::COUNT_BITS-1:0] column_counts [phl_pkg::COLUMNS];

  // Layout derived from the registers
  bit [63:0] grp_lo [3];
  bit [63:0] grp_hi [3];
  bit [63:0] grp_w [3];
  bit [63:0] grp_cols [3];
  bit [63:0] grp_start [3];
  int        groups_used;
  bit [63:0] last_bound;
  bit [63:0] sat_col;

  column_report_t awaited_reports[$];
  int             mismatches;

  function new();
    for (int g = 0; g < 3; g++) begin
      bound_reg[g] = 0;
      width_reg[g] = 1;
    end
    foreach (column_counts[i]) column_counts[i] = '0;
    mismatches = 0;
    rebuild_layout();
  endfunction

  // Place groups back to back; clamp descending bounds and zero widths
  function void rebuild_layout();
    bit [63:0] prev;
    bit [63:0] total;
    bit [63:0] b;
    bit [63:0] w;
    prev = 0;
    total = 0;
    groups_used = (phl_pkg::GROUPS < 3) ? phl_pkg::GROUPS : 3;
    for (int g = 0; g < 3; g++) begin
      grp_lo[g] = 0;
      grp_hi[g] = 0;
      grp_w[g] = 1;
      grp_cols[g] = 0;
      grp_start[g] = 0;
    end
    for (int g = 0; g < groups_used; g++) begin
      b = (bound_reg[g] < prev) ? prev : 64'(bound_reg[g]);
      w = (width_reg[g] == 0) ? 64'd1 : 64'(width_reg[g]);
      grp_lo[g] = prev;
      grp_hi[g] = b;
      grp_w[g] = w;
      grp_cols[g] = (b - prev) / w;
      grp_start[g] = total;
      total += grp_cols[g];
      prev = b;
    end
    last_bound = prev;
    sat_col = (total < phl_pkg::COLUMNS - 1) ? total : 64'(phl_pkg::COLUMNS - 1);
  endfunction

  function bit [63:0] left_edge_of(bit [63:0] col);
    for (int g = 0; g < groups_used; g++)
      if (col >= grp_start[g] && col < grp_start[g] + grp_cols[g])
        return grp_lo[g] + (col - grp_start[g]) * grp_w[g];
    return last_bound;
  endfunction

  function void write_reg(bit [phl_pkg::CFG_IDX_W-1:0] index, bit [31:0] value);
    case (index)
      phl_pkg::REG_BOUND_FIRST:  bound_reg[0] = value;
      phl_pkg::REG_WIDTH_FIRST:  width_reg[0] = value;
      phl_pkg::REG_BOUND_SECOND: bound_reg[1] = value;
      phl_pkg::REG_WIDTH_SECOND: width_reg[1] = value;
      phl_pkg::REG_BOUND_THIRD:  bound_reg[2] = value;
      phl_pkg::REG_WIDTH_THIRD:  width_reg[2] = value;
      default: ;
    endcase
    rebuild_layout();
  endfunction

  // Count or look up the column for one accepted request
  function void note_request(logic cmd, bit [31:0] duration_us, bit [7:0] column_sel);
    column_report_t r;
    bit [63:0]      col;
    int             hit_grp;
    r = '{default: 0};
    if (cmd == phl_pkg::CMD_RECORD) begin
      hit_grp = -1;
      for (int g = 0; g < groups_used; g++)
        if (hit_grp < 0 && grp_hi[g] > duration_us) hit_grp = g;
      if (hit_grp < 0) begin
        col = sat_col;
      end else begin
        col = grp_start[hit_grp] + (duration_us - grp_lo[hit_grp]) / grp_w[hit_grp];
        if (col > sat_col) col = sat_col;
      end
      // Hold at the maximum instead of wrapping
      if (column_counts[col] != '1) column_counts[col]++;
      r.count = column_counts[col];
      r.left_edge_us = 32'(left_edge_of(col));
      r.in_saturation = (col == sat_col);
    end else begin
      col = 64'(column_sel);
      if (col > sat_col) begin
        r.bad_column = 1'b1;
      end else begin
        r.count = column_counts[col];
        r.left_edge_us = 32'(left_edge_of(col));
        r.in_saturation = (col == sat_col);
      end
    end
    r.column_hit = col[7:0];
    awaited_reports = {awaited_reports, r};
  endfunction

  function int pending();
    return awaited_reports.size();
  endfunction

  function void note_failure(string msg);
    mismatches++;
    if (mismatches <= 10) $display("ERROR: %s", msg);
  endfunction

  function void compare_field(string field, logic [31:0] actual, bit [31:0] expected);
    if (actual !== expected)
      note_failure($sformatf("%s mismatch: expected %h, got %h", field, expected, actual));
  endfunction

  // Compare one accepted response with the oldest open request
  function void check_response(logic [phl_pkg::OUT_DATA_W-1:0] tdata,
                               logic [phl_pkg::OUT_USER_W-1:0] tuser);
    column_report_t r;
    if (awaited_reports.size() == 0) begin
      note_failure($sformatf("response with no open request: tdata=%h tuser=%b",
                             tdata, tuser));
      return;
    end
    r = awaited_reports.pop_front();
    compare_field("column_hit", 32'(tdata[7:0]), 32'(r.column_hit));
    compare_field("count", tdata[39:8], r.count);
    compare_field("left_edge_us", tdata[71:40], r.left_edge_us);
    compare_field("in_saturation", 32'(tuser[0]), 32'(r.in_saturation));
    compare_field("bad_column", 32'(tuser[1]), 32'(r.bad_column));
  endfunction
endclass

module tb_piecewise_latency_histogram_core;

  localparam int ITEMS_PER_PHASE = 54;
  localparam int RANDOM_PHASES   = 8;
  localparam int HOLD_CYCLES     = 400;
  localparam int DRAIN_CYCLES    = 64;
  localparam int CYCLE_LIMIT     = 600000;

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [phl_pkg::IN_DATA_W-1:0]  in_tdata;
  logic                           in_tuser;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [phl_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [phl_pkg::OUT_USER_W-1:0] out_tuser;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [phl_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [phl_pkg::VAL_W-1:0]      cfg_data;

  hist_scoreboard sb;
  bit             send_burst;
  bit             recv_burst;
  bit             hold_off_pending;
  int             cycle_count = 0;
  bit [31:0]      lay_bound [3];
  bit [31:0]      lay_width [3];

  piecewise_latency_histogram_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Offer one request after a random gap; return at the falling edge after acceptance
  task automatic send_request(logic cmd, bit [31:0] duration_us, bit [7:0] column_sel);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {column_sel, duration_us};
    in_tuser = cmd;
    do @(posedge clk); while (!in_tready);
    sb.note_request(cmd, duration_us, column_sel);
    @(negedge clk);
  endtask

  task automatic record(bit [31:0] duration_us);
    send_request(phl_pkg::CMD_RECORD, duration_us, 8'($urandom));
  endtask

  task automatic read_column(bit [7:0] column_sel);
    send_request(phl_pkg::CMD_READ, $urandom, column_sel);
  endtask

  // Drop the request valid and wait for every open request to come back
  task automatic wait_idle();
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_cfg(logic [phl_pkg::CFG_IDX_W-1:0] index, bit [31:0] value);
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(index, value);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic apply_layout();
    wait_idle();
    write_cfg(phl_pkg::REG_BOUND_FIRST, lay_bound[0]);
    write_cfg(phl_pkg::REG_WIDTH_FIRST, lay_width[0]);
    write_cfg(phl_pkg::REG_BOUND_SECOND, lay_bound[1]);
    write_cfg(phl_pkg::REG_WIDTH_SECOND, lay_width[1]);
    write_cfg(phl_pkg::REG_BOUND_THIRD, lay_bound[2]);
    write_cfg(phl_pkg::REG_WIDTH_THIRD, lay_width[2]);
  endtask

  task automatic set_layout(bit [31:0] b0, bit [31:0] w0, bit [31:0] b1, bit [31:0] w1,
                            bit [31:0] b2, bit [31:0] w2);
    lay_bound[0] = b0;
    lay_width[0] = w0;
    lay_bound[1] = b1;
    lay_width[1] = w1;
    lay_bound[2] = b2;
    lay_width[2] = w2;
    apply_layout();
  endtask

  // Kind 0: small ascending, kind 1: raw random, kind 2: wide ascending,
  // kind 3: wide ascending with few columns per group
  task automatic pick_layout(int kind);
    bit [63:0] acc;
    bit [31:0] t;
    bit [31:0] prev;
    int        cols;
    acc = 0;
    for (int g = 0; g < 3; g++) begin
      lay_bound[g] = $urandom;
      lay_width[g] = $urandom;
    end
    if (kind == 0) begin
      for (int g = 0; g < 3; g++) begin
        lay_width[g] = $urandom_range(1, 40);
        cols = $urandom_range(0, 25);
        acc += cols * lay_width[g] + $urandom_range(0, lay_width[g] - 1);
        lay_bound[g] = acc[31:0];
      end
    end else if (kind >= 2) begin
      // sort bounds ascending
      for (int pass = 0; pass < 2; pass++)
        for (int g = 0; g < 2; g++)
          if (lay_bound[g] > lay_bound[g+1]) begin
            t = lay_bound[g];
            lay_bound[g] = lay_bound[g+1];
            lay_bound[g+1] = t;
          end
      prev = 0;
      for (int g = 0; g < 3; g++) begin
        if (kind == 2)
          lay_width[g] = $urandom >> $urandom_range(0, 31);
        else
          lay_width[g] = (lay_bound[g] - prev) / $urandom_range(1, 40);
        prev = lay_bound[g];
      end
    end
    // occasional zero width
    if ($urandom_range(0, 5) == 0) lay_width[$urandom_range(0, 2)] = 0;
  endtask

  function automatic bit [31:0] pick_duration();
    bit [63:0] top;
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2, 3: return sb.bound_reg[$urandom_range(0, 2)] + $urandom_range(0, 2) - 1;
      default: begin
        top = sb.last_bound + sb.last_bound / 8 + 4;
        if (top > 64'hFFFF_FFFF) top = 64'hFFFF_FFFF;
        return $urandom_range(0, top[31:0]);
      end
    endcase
  endfunction

  function automatic bit [7:0] pick_column();
    bit [63:0] top;
    top = sb.sat_col + 2;
    if (top > 255) top = 255;
    if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, top[31:0]));
  endfunction

  // Response side: random stalls, one long hold-off on request
  initial begin
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      int stall;
      if (hold_off_pending) begin
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_pending = 1'b0;
      end
      stall = recv_burst ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_response(out_tdata, out_tuser);
      @(negedge clk);
    end
  end

  initial begin
    int kind;
    sb = new();
    send_burst = 1'b0;
    recv_burst = 1'b0;
    hold_off_pending = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = phl_pkg::CMD_RECORD;
    cfg_valid = 1'b0;
    cfg_index = phl_pkg::REG_BOUND_FIRST;
    cfg_data = '0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset layout: everything lands in the saturation column at index zero
    record(32'd0);
    record(32'hFFFF_FFFF);
    read_column(8'd0);
    read_column(8'd1);
    read_column(8'd255);

    // Three regular groups: 10 + 9 + 9 columns, saturation at 28
    set_layout(32'd100, 32'd10, 32'd1000, 32'd100, 32'd10000, 32'd1000);
    record(32'd0);
    record(32'd99);
    record(32'd100);
    record(32'd9999);
    record(32'd10000);
    record(32'hFFFF_FFFF);
    read_column(8'd27);
    read_column(8'd28);
    read_column(8'd29);

    // Trailing partial column spills over; descending bound; zero widths
    set_layout(32'd100, 32'd30, 32'd50, 32'd0, 32'd200, 32'd0);
    record(32'd95);
    record(32'd150);
    read_column(8'd3);

    // Capacity overflow into the last column
    set_layout(32'hFFFF_FFFF, 32'd1, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    record(32'd254);
    record(32'd255);
    record(32'hFFFF_FFFE);
    read_column(8'd255);

    // One column of maximum width
    set_layout(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'd1);
    record(32'hFFFF_FFFE);
    record(32'hFFFF_FFFF);
    read_column(8'd0);

    // Random phases over varied layouts
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase < 4) kind = phase;
      else kind = $urandom_range(0, 1) ? 0 : $urandom_range(1, 3);
      pick_layout(kind);
      apply_layout();
      send_burst = ($urandom_range(0, 3) == 0);
      recv_burst = ($urandom_range(0, 3) == 0);
      // Hold off the response side while requests keep coming
      if (phase == 2) begin
        send_burst = 1'b1;
        hold_off_pending = 1'b1;
      end
      repeat (ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 9) < 6) record(pick_duration());
        else read_column(pick_column());
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule

`default_nettype wire
